@@ src/ccfr_pkg.sv @@
package ccfr_pkg;

	localparam int unsigned MAX_LEN     = 16;
	localparam int unsigned COUNT_W     = $clog2(MAX_LEN + 1);
	localparam int unsigned LEN_W       = 5;
	localparam int unsigned LEN_SAT     = (1 << LEN_W) - 1;

	localparam logic [31:0] CRC_POLY    = 32'hEDB88320;
	localparam logic [31:0] CRC_PRESET  = 32'hFFFFFFFF;

	localparam logic [7:0]  START_RESET = 8'h40;
	localparam logic [7:0]  END_RESET   = 8'h5E;

	localparam int unsigned ADDR_W      = 3;

	typedef enum logic [0:0] {
		REG_START_CHAR = 1'b0,
		REG_END_CHAR   = 1'b1
	} reg_idx_t;

	typedef enum logic [1:0] {
		ST_GOOD     = 2'd0,
		ST_BAD      = 2'd1,
		ST_TOO_LONG = 2'd2
	} frame_status_t;

endpackage

@@ src/ccfr_crc_byte.sv @@
module ccfr_crc_byte (
	input  logic [31:0] crc,
	input  logic [7:0]  data,
	output logic [31:0] crc_next
);

	// reflected CRC-32, eight bit steps unrolled
	always_comb begin
		logic [31:0] r;
		r = crc ^ {24'd0, data};
		for (int n = 0; n < 8; n++) begin
			if (r[0]) begin
				r = (r >> 1) ^ ccfr_pkg::CRC_POLY;
			end else begin
				r = r >> 1;
			end
		end
		crc_next = r;
	end

endmodule

@@ src/crc32_checked_frame_receiver.sv @@
// Byte-stream frame receiver with reflected CRC-32 residue check.
// The end byte is taken into the input register; its frame result then goes into
// the result register, which drives out_valid.
// Throughput: one byte per cycle; a stalled result register holds the input stage.
// Reset (arst_n low, asynchronous): hunting for start, CRC preset, count zero,
// no result pending, start_char = 0x40, end_char = 0x5E.
module crc32_checked_frame_receiver (
	input  logic                         clk,
	input  logic                         arst_n,

	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [ccfr_pkg::ADDR_W-1:0]  paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready,

	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [7:0]                   rx_byte,

	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [1:0]                   frame_status,
	output logic [ccfr_pkg::LEN_W-1:0]   frame_length
);

	logic [7:0] start_char_q;
	logic [7:0] end_char_q;
	ccfr_pkg::reg_idx_t reg_idx;

	logic       valid_s1;
	logic [7:0] rx_byte_s1;

	logic                              in_frame_q;
	logic [31:0]                       crc_q;
	logic [ccfr_pkg::COUNT_W-1:0]      count_q;

	logic                              res_valid_q;
	ccfr_pkg::frame_status_t           res_status_q;
	logic [ccfr_pkg::LEN_W-1:0]        res_length_q;

	logic                              advance;
	logic                              emit;
	ccfr_pkg::frame_status_t           emit_status;
	logic [ccfr_pkg::LEN_W-1:0]        cur_length;
	logic [31:0]                       crc_fold;

	// config port
	assign pready  = 1'b1;
	assign reg_idx = ccfr_pkg::reg_idx_t'(paddr[2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_char_q <= ccfr_pkg::START_RESET;
			end_char_q   <= ccfr_pkg::END_RESET;
		end else if (psel && penable && pwrite && pready) begin
			unique case (reg_idx)
				ccfr_pkg::REG_START_CHAR: start_char_q <= pwdata[7:0];
				ccfr_pkg::REG_END_CHAR:   end_char_q   <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			ccfr_pkg::REG_START_CHAR: prdata = {24'd0, start_char_q};
			ccfr_pkg::REG_END_CHAR:   prdata = {24'd0, end_char_q};
			default:                  prdata = 32'd0;
		endcase
	end

	// input register; stage 1 moves only when the result slot can take a transfer
	assign advance  = valid_s1 && (!res_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			rx_byte_s1 <= rx_byte;
		end
	end

	ccfr_crc_byte u_crc (
		.crc      (crc_q),
		.data     (rx_byte_s1),
		.crc_next (crc_fold)
	);

	always_comb begin
		if (32'(count_q) > ccfr_pkg::LEN_SAT) begin
			cur_length = ccfr_pkg::LEN_W'(ccfr_pkg::LEN_SAT);
		end else begin
			cur_length = ccfr_pkg::LEN_W'(count_q);
		end
	end

	always_comb begin
		emit        = 1'b0;
		emit_status = ccfr_pkg::ST_GOOD;
		if (in_frame_q) begin
			if (rx_byte_s1 == end_char_q) begin
				emit        = 1'b1;
				emit_status = (crc_q == 32'd0) ? ccfr_pkg::ST_GOOD : ccfr_pkg::ST_BAD;
			end else if (32'(count_q) >= ccfr_pkg::MAX_LEN) begin
				emit        = 1'b1;
				emit_status = ccfr_pkg::ST_TOO_LONG;
			end
		end
	end

	// frame state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
			crc_q      <= ccfr_pkg::CRC_PRESET;
			count_q    <= '0;
		end else if (advance) begin
			if (!in_frame_q) begin
				if (rx_byte_s1 == start_char_q) begin
					in_frame_q <= 1'b1;
					crc_q      <= ccfr_pkg::CRC_PRESET;
					count_q    <= '0;
				end
			end else if (emit) begin
				in_frame_q <= 1'b0;
				crc_q      <= ccfr_pkg::CRC_PRESET;
				count_q    <= '0;
			end else begin
				crc_q   <= crc_fold;
				count_q <= count_q + 1'b1;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance && emit) begin
			res_valid_q <= 1'b1;
		end else if (out_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			res_status_q <= emit_status;
			res_length_q <= cur_length;
		end
	end

	assign out_valid    = res_valid_q;
	assign frame_status = res_status_q;
	assign frame_length = res_length_q;

endmodule

@@ bench/frame_check.sv @@
`timescale 1ns / 1ps

module frame_check
	import ccfr_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	input  logic              pready,
	input  logic              in_valid,
	input  logic              in_ready,
	input  logic [7:0]        rx_byte,
	input  logic              out_valid,
	input  logic              out_ready,
	input  logic [1:0]        frame_status,
	input  logic [LEN_W-1:0]  frame_length,
	output int                fail_count,
	output int                reports_pending
);

	typedef struct packed {
		frame_status_t     status;
		logic [LEN_W-1:0]  length;
	} frame_report_t;

	frame_report_t       frame_reports[$];
	frame_report_t       want;
	logic [7:0]          start_char;
	logic [7:0]          end_char;
	logic                in_frame;
	logic [31:0]         crc_reg;
	logic [COUNT_W-1:0]  payload_count;
	int                  fails;

	function automatic logic [31:0] crc_fold(input logic [31:0] r, input logic [7:0] b);
		r = r ^ {24'h0, b};
		for (int n = 0; n < 8; n++)
			r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
		return r;
	endfunction

	function automatic frame_report_t close_report(input frame_status_t st);
		frame_report_t r;
		r.status = st;
		r.length = (payload_count > LEN_SAT) ? LEN_SAT[LEN_W-1:0] : payload_count[LEN_W-1:0];
		return r;
	endfunction

	function automatic void note_failure(input string msg);
		fails++;
		if (fails <= 10)
			$display("%0t: %s", $realtime, msg);
	endfunction

	// Frame state update for one transferred byte; queues a report when the frame closes.
	task automatic take_byte(input logic [7:0] b);
		if (!in_frame) begin
			if (b == start_char) begin
				in_frame      = 1'b1;
				crc_reg       = CRC_PRESET;
				payload_count = '0;
			end
		end else if (b == end_char) begin
			frame_reports.push_back(close_report((crc_reg == 32'h0) ? ST_GOOD : ST_BAD));
			in_frame = 1'b0;
		end else if (payload_count >= MAX_LEN) begin
			// overflowing byte is dropped, not taken as a start
			frame_reports.push_back(close_report(ST_TOO_LONG));
			in_frame = 1'b0;
		end else begin
			crc_reg       = crc_fold(crc_reg, b);
			payload_count = payload_count + 1'b1;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_char      = START_RESET;
			end_char        = END_RESET;
			in_frame        = 1'b0;
			crc_reg         = CRC_PRESET;
			payload_count   = '0;
			fails           = 0;
			frame_reports.delete();
			fail_count      <= 0;
			reports_pending <= 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (reg_idx_t'(paddr[ADDR_W-1:2]))
					REG_START_CHAR: start_char = pwdata[7:0];
					REG_END_CHAR:   end_char   = pwdata[7:0];
					default: ;
				endcase
			end
			if (out_valid && out_ready) begin
				if (frame_reports.size() == 0) begin
					note_failure($sformatf("unexpected report: status %0d length %0d",
						frame_status, frame_length));
				end else begin
					want = frame_reports.pop_front();
					if (frame_status !== want.status || frame_length !== want.length)
						note_failure($sformatf(
							"report mismatch: status exp %0d got %0d, length exp %0d got %0d",
							want.status, frame_status, want.length, frame_length));
				end
			end
			if (in_valid && in_ready)
				take_byte(rx_byte);
			fail_count      <= fails;
			reports_pending <= frame_reports.size();
		end
	end

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
	import ccfr_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;

	logic              clk       = 1'b0;
	logic              arst_n    = 1'b0;
	logic              psel      = 1'b0;
	logic              penable   = 1'b0;
	logic              pwrite    = 1'b0;
	logic [ADDR_W-1:0] paddr     = '0;
	logic [31:0]       pwdata    = '0;
	logic [31:0]       prdata;
	logic              pready;
	logic              in_valid  = 1'b0;
	logic              in_ready;
	logic [7:0]        rx_byte   = 8'h00;
	logic              out_valid;
	logic              out_ready = 1'b0;
	logic [1:0]        frame_status;
	logic [LEN_W-1:0]  frame_length;
	int                fail_count;
	int                reports_pending;

	bit                idling = 1'b1;
	int                stall_left = 0;
	int                quiet_cycles = 0;
	int                bytes_sent = 0;
	logic [7:0]        cur_start = START_RESET;
	logic [7:0]        cur_end   = END_RESET;

	crc32_checked_frame_receiver uut (.*);
	frame_check checker_i (.*);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// result-side backpressure
	always @(posedge clk) begin
		if (stall_left != 0) begin
			stall_left <= stall_left - 1;
		end else if (idling && $urandom_range(0, 7) == 0) begin
			out_ready  <= 1'b0;
			stall_left <= $urandom_range(1, 17) - 1;
		end else begin
			out_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles == WATCHDOG_LIMIT) begin
				$display("RESULT: ERROR");
				$finish;
			end
		end
	end

	task automatic send_byte(input logic [7:0] b);
		if (idling && $urandom_range(0, 9) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte  <= b;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		bytes_sent++;
	endtask

	task automatic reg_write(input reg_idx_t idx, input logic [7:0] val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= {24'h0, val};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	// Wait until every report is back; bytes that close nothing may still be in the pipe.
	task automatic drain;
		in_valid <= 1'b0;
		do @(posedge clk); while (reports_pending != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_chars(input logic [7:0] s, input logic [7:0] e);
		drain();
		reg_write(REG_START_CHAR, s);
		reg_write(REG_END_CHAR, e);
		cur_start = s;
		cur_end   = e;
	endtask

	function automatic logic [31:0] body_crc(input logic [7:0] body[$]);
		logic [31:0] r;
		r = CRC_PRESET;
		foreach (body[i]) begin
			r = r ^ {24'h0, body[i]};
			for (int k = 0; k < 8; k++)
				r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
		end
		return r;
	endfunction

	task automatic send_frame(input logic [7:0] body[$]);
		send_byte(cur_start);
		foreach (body[i])
			send_byte(body[i]);
		send_byte(cur_end);
	endtask

	task automatic rand_frame;
		logic [7:0]  body[$];
		logic [7:0]  b;
		logic [31:0] c;
		int          kind;
		int          n;
		int          pos;
		kind = $urandom_range(0, 99);
		if (kind < 10) begin
			// line noise while hunting
			repeat ($urandom_range(1, 6)) send_byte(8'($urandom));
		end else begin
			if (kind >= 75 && kind < 85)
				n = $urandom_range(MAX_LEN, MAX_LEN + 4);
			else if (kind < 75)
				n = $urandom_range(0, MAX_LEN - 4);
			else
				n = $urandom_range(0, MAX_LEN - 1);
			repeat (n) begin
				do b = 8'($urandom); while (b == cur_end);
				body.push_back(b);
			end
			if (kind < 75) begin
				// appending the raw register LSB first drives the residue to zero
				c = body_crc(body);
				for (int k = 0; k < 4; k++)
					body.push_back(c[8*k +: 8]);
			end
			if (kind >= 60 && kind < 75) begin
				pos = $urandom_range(0, body.size() - 1);
				body[pos] = body[pos] ^ (8'h01 << $urandom_range(0, 7));
			end
			send_frame(body);
		end
	endtask

	task automatic run_until(input int target);
		while (bytes_sent < target)
			rand_frame();
	endtask

	initial begin
		logic [7:0]  good_body[$];
		logic [7:0]  empty_body[$];
		logic [31:0] c;
		logic [7:0]  s_rand;
		logic [7:0]  e_rand;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// hunting drops everything but the start byte
		send_byte(8'h00);
		send_byte(8'hFF);
		// start byte inside a frame is plain payload
		send_frame('{8'h00, 8'hFF, START_RESET});
		// empty frame: register still preset, so it reads as bad
		send_frame(empty_body);
		good_body.push_back(8'hA5);
		c = body_crc(good_body);
		for (int k = 0; k < 4; k++)
			good_body.push_back(c[8*k +: 8]);
		send_frame(good_body);

		set_chars(8'h00, 8'hFF);
		run_until(180);
		set_chars(8'hFF, 8'h00);
		run_until(340);
		// start and end share one value
		set_chars(8'h7E, 8'h7E);
		run_until(500);
		s_rand = 8'($urandom);
		e_rand = ($urandom_range(0, 3) == 0) ? s_rand : 8'($urandom);
		set_chars(s_rand, e_rand);
		run_until(680);
		idling = 1'b0;
		set_chars(START_RESET, END_RESET);
		run_until(760);

		drain();
		repeat (8) @(posedge clk);
		if (fail_count == 0 && reports_pending == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
